// ===== rtl/core/jrv_pkg.sv =====
`timescale 1ns / 1ps

package jrv_pkg;

  localparam int POS_W        = 10;
  localparam int TOKEN_LIM_W  = 9;
  localparam int CRED_LIM_W   = 7;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 9;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 3;

  localparam logic [31:0] JR_MAGIC = 32'h5450_4D50;
  localparam logic [31:0] JR_POLY  = 32'hEDB8_8320;

  localparam logic [POS_W-1:0] JR_CRC_BYTES    = 10'd4;
  localparam logic [POS_W-1:0] JR_MIN_RECORD   = 10'd20;
  localparam logic [POS_W-1:0] JR_HEADER_BYTES = 10'd16;
  localparam logic [POS_W-1:0] OFS_VERSION     = 10'd4;
  localparam logic [POS_W-1:0] OFS_RESERVED    = 10'd6;
  localparam logic [POS_W-1:0] OFS_GENERATION  = 10'd8;

  localparam logic [TOKEN_LIM_W-1:0] TOKEN_LIMIT_RESET = 9'd256;
  localparam logic [CRED_LIM_W-1:0]  CRED_LIMIT_RESET  = 7'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOKEN_LIMIT      = 1'b0,
    REG_CREDENTIAL_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_VERSION   = 4'd3,
    ST_ZERO_GEN  = 4'd4,
    ST_CRC       = 4'd5,
    ST_TOO_LONG  = 4'd6,
    ST_OVERRUN   = 4'd7,
    ST_TRAILING  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_CONTENT = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic gen_nonzero;
    logic version_bad;
    logic magic_bad;
  } hdr_flags_t;

  typedef struct packed {
    logic [TOKEN_LIM_W-1:0] token_limit;
    logic [CRED_LIM_W-1:0]  credential_limit;
  } cfg_t;

  typedef struct packed {
    logic        has_content;
    logic [1:0]  field_index;
    logic [7:0]  payload_byte;
    logic        has_verdict;
    status_t     status;
    logic [63:0] generation;
  } pkt_t;

  function automatic logic [31:0] jrv_crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ JR_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/jrv_channels.sv =====
`timescale 1ns / 1ps

interface jrv_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_record;

  modport source (output valid, data_byte, end_of_record, input ready);
  modport sink (input valid, data_byte, end_of_record, output ready);
endinterface

interface jrv_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  field_index;
  logic [7:0]  payload_byte;
  logic [3:0]  status;
  logic [63:0] generation;
  logic        last_of_run;

  modport source (output valid, result_kind, field_index, payload_byte, status, generation,
                  last_of_run, input ready);
  modport sink (input valid, result_kind, field_index, payload_byte, status, generation,
                last_of_run, output ready);
endinterface

interface jrv_cfg_if import jrv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/journal_record_validator.sv =====
`timescale 1ns / 1ps
// a byte accepted is registered in the input stage, then parsed, and its results are written into the result queue
// throughput: one byte per cycle while input ready is high; the final byte of a record may yield two results,
//   drained one per cycle, while the result port is ready, from a four-packet result queue
// input ready drops while the queued packets and the input stage add up to four
// reset: synchronous, clears record state, queue and input stage; limits return to 256 and 64

module journal_record_validator import jrv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jrv_rec_if.sink   rec,
  jrv_cfg_if.sink   cfg,
  jrv_res_if.source res
);

  cfg_t                  limits;
  logic                  stg_valid;
  logic [7:0]            stg_byte;
  logic                  stg_eor;
  logic                  push;
  pkt_t                  push_pkt;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign cfg.ready = 1'b1;
  assign rec.ready = (fifo_count + FIFO_CNT_W'(stg_valid)) < FIFO_CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.token_limit      <= TOKEN_LIMIT_RESET;
      limits.credential_limit <= CRED_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_TOKEN_LIMIT:      limits.token_limit      <= cfg.data[TOKEN_LIM_W-1:0];
        REG_CREDENTIAL_LIMIT: limits.credential_limit <= cfg.data[CRED_LIM_W-1:0];
        default:              limits                  <= limits;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= rec.valid && rec.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rec.valid && rec.ready) begin
      stg_byte <= rec.data_byte;
      stg_eor  <= rec.end_of_record;
    end
  end

  jrv_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid),
    .in_byte  (stg_byte),
    .in_eor   (stg_eor),
    .cfg      (limits),
    .push     (push),
    .pkt      (push_pkt)
  );

  jrv_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .count    (fifo_count),
    .res      (res)
  );

endmodule

// ===== rtl/core/jrv_parser.sv =====
`timescale 1ns / 1ps

module jrv_parser import jrv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_eor,
  input  cfg_t       cfg,
  output logic       push,
  output pkt_t       pkt
);

  logic [7:0]       tail [4];
  logic [7:0]       tail_next [4];
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]      crc, crc_next;
  hdr_flags_t       flags, flags_next;
  logic [63:0]      gen, gen_next;
  logic [1:0]       field_number, field_number_next;
  phase_t           phase, phase_next;
  logic [8:0]       bytes_left, bytes_left_next;
  status_t          first_error, first_error_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        tail[i] <= 8'd0;
      end
      byte_position <= '0;
      crc           <= '1;
      flags         <= '0;
      gen           <= '0;
      field_number  <= 2'd0;
      phase         <= PH_LEN_LO;
      bytes_left    <= '0;
      first_error   <= ST_OK;
    end else begin
      tail          <= tail_next;
      byte_position <= byte_position_next;
      crc           <= crc_next;
      flags         <= flags_next;
      gen           <= gen_next;
      field_number  <= field_number_next;
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      first_error   <= first_error_next;
    end
  end

  always_comb begin
    logic [7:0]       old;
    logic [POS_W-1:0] p;
    logic [15:0]      len;
    logic [15:0]      lim;
    logic [8:0]       dec;
    logic             done;
    logic             emit;
    logic [1:0]       fld;
    status_t          st;
    logic [31:0]      expect_crc;

    tail_next          = tail;
    byte_position_next = byte_position;
    crc_next           = crc;
    flags_next         = flags;
    gen_next           = gen;
    field_number_next  = field_number;
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    first_error_next   = first_error;

    old        = tail[0];
    p          = byte_position - JR_CRC_BYTES;
    len        = {old, bytes_left[7:0]};
    lim        = (field_number == 2'd0) ? 16'(cfg.token_limit) : 16'(cfg.credential_limit);
    dec        = bytes_left - 9'd1;
    done       = 1'b0;
    emit       = 1'b0;
    fld        = field_number;
    st         = ST_OK;
    expect_crc = {in_byte, tail[3], tail[2], tail[1]};

    if (in_valid) begin
      if (byte_position >= JR_CRC_BYTES) begin
        crc_next = jrv_crc_byte(crc, old);
        priority if (p < OFS_VERSION) begin
          if (old != JR_MAGIC[8*p[1:0] +: 8]) flags_next.magic_bad = 1'b1;
        end else if (p < OFS_RESERVED) begin
          if (old != ((p == OFS_VERSION) ? 8'd1 : 8'd0)) flags_next.version_bad = 1'b1;
        end else if (p < OFS_GENERATION) begin
          // reserved bytes
        end else if (p < JR_HEADER_BYTES) begin
          gen_next[8*p[2:0] +: 8] = old;
          if (old != 8'd0) flags_next.gen_nonzero = 1'b1;
        end else if (first_error == ST_OK) begin
          unique case (phase)
            PH_LEN_LO: begin
              bytes_left_next = {1'b0, old};
              phase_next      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              if (len > lim) begin
                first_error_next = ST_TOO_LONG;
              end else begin
                bytes_left_next = len[8:0];
                if (len == 16'd0) done = 1'b1;
                else phase_next = PH_CONTENT;
              end
            end
            PH_CONTENT: begin
              emit            = 1'b1;
              bytes_left_next = dec;
              if (dec == 9'd0) done = 1'b1;
            end
            PH_DONE: begin
              first_error_next = ST_TRAILING;
            end
            default: begin
              first_error_next = first_error;
            end
          endcase
          if (done) begin
            if (field_number >= 2'd2) begin
              phase_next = PH_DONE;
            end else begin
              field_number_next = field_number + 2'd1;
              phase_next        = PH_LEN_LO;
            end
          end
        end else begin
          // walk halted by an earlier field error
          first_error_next = first_error;
        end
      end

      tail_next[0] = tail[1];
      tail_next[1] = tail[2];
      tail_next[2] = tail[3];
      tail_next[3] = in_byte;
      if (byte_position != '1) byte_position_next = byte_position + 1'b1;

      priority if (byte_position_next < JR_MIN_RECORD) st = ST_SHORT;
      else if (flags_next.magic_bad) st = ST_MAGIC;
      else if (flags_next.version_bad) st = ST_VERSION;
      else if (!flags_next.gen_nonzero) st = ST_ZERO_GEN;
      else if (~crc_next != expect_crc) st = ST_CRC;
      else if (first_error_next != ST_OK) st = first_error_next;
      else if (phase_next != PH_DONE) st = ST_OVERRUN;
      else st = ST_OK;
    end

    pkt.has_content  = emit;
    pkt.field_index  = fld;
    pkt.payload_byte = old;
    pkt.has_verdict  = in_eor;
    pkt.status       = st;
    pkt.generation   = (st == ST_OK) ? gen_next : 64'd0;
    push             = in_valid && (emit || in_eor);

    // new record starts from the cleared state
    if (in_valid && in_eor) begin
      for (int i = 0; i < 4; i++) begin
        tail_next[i] = 8'd0;
      end
      byte_position_next = '0;
      crc_next           = '1;
      flags_next         = '0;
      gen_next           = '0;
      field_number_next  = 2'd0;
      phase_next         = PH_LEN_LO;
      bytes_left_next    = '0;
      first_error_next   = ST_OK;
    end
  end

  a_record_cleared: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_eor |=> byte_position == '0 && crc == '1 && first_error == ST_OK)
    else $error("record state not cleared after verdict");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    first_error == ST_OK || first_error == ST_TOO_LONG || first_error == ST_TRAILING)
    else $error("unexpected stored field error");

  a_content_in_walk: assert property (@(posedge clk) disable iff (rst)
    push && pkt.has_content |-> phase == PH_CONTENT && first_error == ST_OK)
    else $error("content byte outside a field");

endmodule

// ===== rtl/core/jrv_result_fifo.sv =====
`timescale 1ns / 1ps

module jrv_result_fifo import jrv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pkt_t                  push_pkt,
  output logic [FIFO_CNT_W-1:0] count,
  jrv_res_if.source             res
);

  pkt_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  sel;
  pkt_t                  head;
  logic                  verdict_now;
  logic                  take;
  logic                  pop;

  assign head        = entries[rd_ptr];
  assign verdict_now = !head.has_content || sel;
  assign take        = res.valid && res.ready;
  assign pop         = take && (verdict_now || !head.has_verdict);

  assign res.valid        = (count != '0);
  assign res.result_kind  = verdict_now;
  assign res.field_index  = verdict_now ? 2'd0 : head.field_index;
  assign res.payload_byte = verdict_now ? 8'd0 : head.payload_byte;
  assign res.status       = verdict_now ? head.status : ST_OK;
  assign res.generation   = verdict_now ? head.generation : 64'd0;
  assign res.last_of_run  = verdict_now || !head.has_verdict;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      // second request of a two-result packet
      if (pop) sel <= 1'b0;
      else if (take) sel <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != FIFO_CNT_W'(FIFO_DEPTH) || pop)
    else $error("result queue overflow");

  a_sel_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> count != '0 && head.has_content && head.has_verdict)
    else $error("verdict select without a two-result packet");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule
